[design/cag_pkg.sv]
// shared types and constants for the cumulative average gain unit
// used by cag_front, cag_queue, cag_back and the top level; no dependencies
package cag_pkg;

  // field widths
  localparam int SAMPLE_WIDTH    = 16;
  localparam int MODE_WIDTH      = 2;
  localparam int GAIN_WIDTH      = 16;
  localparam int OUT_WIDTH       = 32;
  localparam int SUM_WIDTH       = 48;
  localparam int COUNT_WIDTH     = 31;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // count at which all state is cleared
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;

  // divider steps, one quotient bit per cycle
  localparam int DIV_STEPS  = SUM_WIDTH;
  localparam int STEP_WIDTH = $clog2(DIV_STEPS);

  // product of quotient and gain, and the Q8.8 fraction bits
  localparam int PROD_WIDTH = SUM_WIDTH + GAIN_WIDTH + 1;
  localparam int GAIN_FRAC  = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd256;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN            = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUT_OF_SERVICE  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INPUT_CONNECTED = 2'd2;

  // input modes
  localparam logic [MODE_WIDTH-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_AVG   = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_ACC   = 2'd2;

  // classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_AVG   = 3'd1,
    OP_ACC   = 3'd2,
    OP_NOP   = 3'd3,
    OP_BAD   = 3'd4
  } op_t;

  typedef struct packed {
    op_t                            op;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } queue_entry_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SAT  = 5'b01000,
    ST_PUT  = 5'b10000
  } back_state_t;

endpackage

[design/cag_front.sv]
// front end: configuration registers and classification of input items
// depends on cag_pkg
module cag_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cag_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [cag_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cag_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic [cag_pkg::MODE_WIDTH-1:0]         in_mode,
  input  logic                                   queue_full,
  output logic                                   push,
  output cag_pkg::queue_entry_t                  push_entry,
  output logic [cag_pkg::GAIN_WIDTH-1:0]         gain
);

  logic [cag_pkg::GAIN_WIDTH-1:0] gain_r;
  logic                           oos_r;
  logic                           connected_r;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign gain      = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= cag_pkg::GAIN_RESET;
      oos_r       <= 1'b0;
      connected_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        cag_pkg::CFG_GAIN:            gain_r      <= cfg_data;
        cag_pkg::CFG_OUT_OF_SERVICE:  oos_r       <= cfg_data[0];
        cag_pkg::CFG_INPUT_CONNECTED: connected_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // accept whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // classify the transfer into one back end operation
  always_comb begin
    push_entry.sample = in_sample;
    if (oos_r || !connected_r) begin
      push_entry.op = cag_pkg::OP_BAD;
    end else begin
      case (in_mode)
        cag_pkg::MODE_CLEAR: push_entry.op = cag_pkg::OP_CLEAR;
        cag_pkg::MODE_AVG:   push_entry.op = cag_pkg::OP_AVG;
        cag_pkg::MODE_ACC:   push_entry.op = cag_pkg::OP_ACC;
        default:             push_entry.op = cag_pkg::OP_NOP;
      endcase
    end
  end

endmodule

[design/cag_queue.sv]
// short flop queue of classified operations between front and back
// depends on cag_pkg
module cag_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cag_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output cag_pkg::queue_entry_t head
);

  cag_pkg::queue_entry_t                 mem_r [cag_pkg::QUEUE_DEPTH];
  logic [cag_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cag_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cag_pkg::QUEUE_CNT_WIDTH-1:0]   fill_r, fill_nxt;

  assign full      = (fill_r == cag_pkg::QUEUE_CNT_WIDTH'(cag_pkg::QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      if (wr_ptr_r == cag_pkg::QUEUE_PTR_WIDTH'(cag_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_r == cag_pkg::QUEUE_PTR_WIDTH'(cag_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/cag_back.sv]
// back end: running state, serial divider, gain multiply and result register
// depends on cag_pkg
module cag_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  op_valid,
  input  cag_pkg::queue_entry_t                 op_entry,
  output logic                                  op_pop,
  input  logic [cag_pkg::GAIN_WIDTH-1:0]        gain,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cag_pkg::OUT_WIDTH-1:0]  out_average_out,
  output logic                                  out_bad
);

  cag_pkg::back_state_t                       state_r, state_nxt;
  logic signed [cag_pkg::SUM_WIDTH-1:0]       sum_r, sum_nxt;
  logic [cag_pkg::COUNT_WIDTH-1:0]            count_r, count_nxt;
  logic signed [cag_pkg::OUT_WIDTH-1:0]       held_r, held_nxt;
  logic [cag_pkg::COUNT_WIDTH-1:0]            rem_r, rem_nxt;
  logic [cag_pkg::SUM_WIDTH-1:0]              quo_r, quo_nxt;
  logic                                       neg_r, neg_nxt;
  logic [cag_pkg::STEP_WIDTH-1:0]             step_r, step_nxt;
  logic signed [cag_pkg::PROD_WIDTH-1:0]      prod_r, prod_nxt;
  logic signed [cag_pkg::OUT_WIDTH-1:0]       res_r, res_nxt;
  logic                                       res_bad_r, res_bad_nxt;
  logic                                       out_valid_r, out_valid_nxt;
  logic signed [cag_pkg::OUT_WIDTH-1:0]       out_avg_r, out_avg_nxt;
  logic                                       out_bad_r, out_bad_nxt;

  logic signed [cag_pkg::SUM_WIDTH-1:0]       sum_add;
  logic [cag_pkg::COUNT_WIDTH-1:0]            count_inc;
  logic [cag_pkg::COUNT_WIDTH:0]              div_shift;
  logic [cag_pkg::COUNT_WIDTH+1:0]            div_diff;
  logic signed [cag_pkg::SUM_WIDTH-1:0]       quo_signed;
  logic signed [cag_pkg::PROD_WIDTH-1:0]      avg_full;
  logic signed [cag_pkg::OUT_WIDTH-1:0]       avg_sat;
  logic                                       out_free;

  // saturating add of one sample to the running sum
  function automatic logic signed [cag_pkg::SUM_WIDTH-1:0] sat_add(
    input logic signed [cag_pkg::SUM_WIDTH-1:0]    s,
    input logic signed [cag_pkg::SAMPLE_WIDTH-1:0] x
  );
    logic signed [cag_pkg::SUM_WIDTH:0] wide;
    wide = {s[cag_pkg::SUM_WIDTH-1], s}
         + {{(cag_pkg::SUM_WIDTH + 1 - cag_pkg::SAMPLE_WIDTH){x[cag_pkg::SAMPLE_WIDTH-1]}}, x};
    if (wide[cag_pkg::SUM_WIDTH] != wide[cag_pkg::SUM_WIDTH-1]) begin
      sat_add = wide[cag_pkg::SUM_WIDTH]
              ? {1'b1, {(cag_pkg::SUM_WIDTH-1){1'b0}}}
              : {1'b0, {(cag_pkg::SUM_WIDTH-1){1'b1}}};
    end else begin
      sat_add = wide[cag_pkg::SUM_WIDTH-1:0];
    end
  endfunction

  assign sum_add   = sat_add(sum_r, op_entry.sample);
  assign count_inc = count_r + 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // one restoring division step: remainder stays below the divisor
  assign div_shift = {rem_r, quo_r[cag_pkg::SUM_WIDTH-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, count_r};

  // signed quotient, truncated toward zero
  assign quo_signed = neg_r ? -quo_r : quo_r;

  // drop the gain fraction (floor) and clamp to the output range
  assign avg_full = prod_r >>> cag_pkg::GAIN_FRAC;
  always_comb begin
    if ((&avg_full[cag_pkg::PROD_WIDTH-1:cag_pkg::OUT_WIDTH-1])
        || !(|avg_full[cag_pkg::PROD_WIDTH-1:cag_pkg::OUT_WIDTH-1])) begin
      avg_sat = avg_full[cag_pkg::OUT_WIDTH-1:0];
    end else if (avg_full[cag_pkg::PROD_WIDTH-1]) begin
      avg_sat = {1'b1, {(cag_pkg::OUT_WIDTH-1){1'b0}}};
    end else begin
      avg_sat = {1'b0, {(cag_pkg::OUT_WIDTH-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_bad_nxt   = out_bad_r;
    op_pop        = 1'b0;

    // result taken by the receiver
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cag_pkg::ST_IDLE: begin
        if (op_valid) begin
          op_pop      = 1'b1;
          res_bad_nxt = 1'b0;
          res_nxt     = held_r;
          state_nxt   = cag_pkg::ST_PUT;
          case (op_entry.op)
            cag_pkg::OP_CLEAR: begin
              sum_nxt   = '0;
              count_nxt = '0;
              held_nxt  = '0;
              res_nxt   = '0;
            end
            cag_pkg::OP_ACC: begin
              sum_nxt = sum_add;
            end
            cag_pkg::OP_AVG: begin
              if (count_inc == cag_pkg::COUNT_LIMIT) begin
                // count limit reached: everything starts over
                sum_nxt   = '0;
                count_nxt = '0;
                held_nxt  = '0;
                res_nxt   = '0;
              end else begin
                sum_nxt   = sum_add;
                count_nxt = count_inc;
                neg_nxt   = sum_add[cag_pkg::SUM_WIDTH-1];
                quo_nxt   = sum_add[cag_pkg::SUM_WIDTH-1] ? -sum_add : sum_add;
                rem_nxt   = '0;
                step_nxt  = '0;
                state_nxt = cag_pkg::ST_DIV;
              end
            end
            cag_pkg::OP_BAD: begin
              res_bad_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      cag_pkg::ST_DIV: begin
        if (!div_diff[cag_pkg::COUNT_WIDTH+1]) begin
          rem_nxt = div_diff[cag_pkg::COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[cag_pkg::SUM_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[cag_pkg::COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[cag_pkg::SUM_WIDTH-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == cag_pkg::STEP_WIDTH'(cag_pkg::DIV_STEPS - 1)) begin
          state_nxt = cag_pkg::ST_MUL;
        end
      end
      cag_pkg::ST_MUL: begin
        prod_nxt  = quo_signed * $signed({1'b0, gain});
        state_nxt = cag_pkg::ST_SAT;
      end
      cag_pkg::ST_SAT: begin
        held_nxt  = avg_sat;
        res_nxt   = avg_sat;
        state_nxt = cag_pkg::ST_PUT;
      end
      cag_pkg::ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = cag_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cag_pkg::ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cag_pkg::ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    neg_r     <= neg_nxt;
    step_r    <= step_nxt;
    prod_r    <= prod_nxt;
    res_r     <= res_nxt;
    res_bad_r <= res_bad_nxt;
    out_avg_r <= out_avg_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_average_out = out_avg_r;
  assign out_bad         = out_bad_r;

endmodule

[design/cumulative_average_gain_unit.sv]
// Cumulative moving average scaled by an unsigned Q8.8 gain.
//
// Channels: in_sample/in_mode arrive on a valid/ready input channel; each
// transfer yields exactly one result on out_average_out/out_bad. Registers
// gain, out_of_service and input_connected are written through the cfg
// channel (indexes 0, 1, 2), which is always ready; write them only while
// the block is idle.
// Path: clear, accumulate-only, bad and unknown-mode items pass from the
// queue entry through the back end idle and put states to the output
// register. Averaging items also pass through the bit-serial divider (one
// quotient bit per cycle over the 48-bit sum), the gain multiply and the
// fraction drop (floor) and clamp. The back end takes its next item only
// once the current result is in the output register.
// A two-entry queue takes new items while the back end works.
// Reset (synchronous, rst_n low) clears sum, count and held output, sets
// gain to 1.0, in service and input connected.
// When the receiver stalls, the result holds in the output register; the
// back end then waits and the queue fills, after which in_ready drops.
// depends on cag_pkg, cag_front, cag_queue, cag_back
module cumulative_average_gain_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cag_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [cag_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [cag_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic [cag_pkg::MODE_WIDTH-1:0]          in_mode,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cag_pkg::OUT_WIDTH-1:0]    out_average_out,
  output logic                                    out_bad
);

  logic                           push;
  cag_pkg::queue_entry_t          push_entry;
  logic                           queue_full;
  logic                           pop;
  logic                           queue_not_empty;
  cag_pkg::queue_entry_t          head;
  logic [cag_pkg::GAIN_WIDTH-1:0] gain;

  // register file and classification
  cag_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_mode    (in_mode),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry),
    .gain       (gain)
  );

  // decoupling queue
  cag_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  // execution and result register
  cag_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_valid        (queue_not_empty),
    .op_entry        (head),
    .op_pop          (pop),
    .gain            (gain),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_average_out (out_average_out),
    .out_bad         (out_bad)
  );

endmodule
